[rtl/core/eud_pkg.sv]
// Shared types, opcode constants and helpers for the EHABI unwind opcode decoder.
package eud_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_ALLOC    = 3'd0;
    localparam logic [2:0] KIND_DEALLOC  = 3'd1;
    localparam logic [2:0] KIND_POP_ONE  = 3'd2;
    localparam logic [2:0] KIND_POP_MANY = 3'd3;
    localparam logic [2:0] KIND_SP_MOVE  = 3'd4;
    localparam logic [2:0] KIND_FINISH   = 3'd5;
    localparam logic [2:0] KIND_OPAQUE   = 3'd6;
    localparam logic [2:0] KIND_NONE     = 3'd7;

    // Register classes.
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_GP   = 2'd1;
    localparam logic [1:0] CLS_FP   = 2'd2;

    // Stream status codes.
    localparam logic [1:0] STAT_MORE   = 2'd0;
    localparam logic [1:0] STAT_FINISH = 2'd1;
    localparam logic [1:0] STAT_END_OK = 2'd2;
    localparam logic [1:0] STAT_TRUNC  = 2'd3;

    // Whole opcode bytes.
    localparam logic [7:0] OP_FINISH  = 8'hB0;
    localparam logic [7:0] OP_POP_LOW = 8'hB1;
    localparam logic [7:0] OP_ULEB    = 8'hB2;
    localparam logic [7:0] OP_VFP_X   = 8'hB3;
    localparam logic [7:0] OP_SPARE_A = 8'hC6;
    localparam logic [7:0] OP_SPARE_B = 8'hC7;
    localparam logic [7:0] OP_VFP_HI  = 8'hC8;
    localparam logic [7:0] OP_VFP_LO  = 8'hC9;

    // Opcode groups by their upper bits.
    localparam logic [1:0] GRP_ALLOC     = 2'b00;
    localparam logic [1:0] GRP_DEALLOC   = 2'b01;
    localparam logic [3:0] GRP_POP_MASK  = 4'h8;
    localparam logic [3:0] GRP_SP_MOVE   = 4'h9;
    localparam logic [4:0] GRP_POP_R4    = 5'b10100;
    localparam logic [4:0] GRP_POP_R4_LR = 5'b10101;
    localparam logic [4:0] GRP_VFP_D8X   = 5'b10111;
    localparam logic [4:0] GRP_VFP_D8    = 5'b11010;

    // Register numbers that cannot be an sp source.
    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_PC = 4'd15;

    localparam logic [63:0] ULEB_BASE  = 64'h204;
    localparam int          OUT_BITS   = 147;
    localparam int          TDATA_BITS = 152;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_PAIR,
        PEND_ULEB
    } pend_t;

    typedef struct packed {
        pend_t       pending;
        logic [7:0]  held_first_byte;
        logic [11:0] byte_position;
        logic [11:0] opcode_start;
        logic [63:0] uleb_value;
        logic [6:0]  uleb_shift;
        logic [7:0]  uleb_bytes;
        logic        stopped;
        logic        refuse_seen;
    } eud_state_t;

    localparam eud_state_t STATE_CLEAR = '{
        pending:         PEND_NONE,
        held_first_byte: 8'd0,
        byte_position:   12'd0,
        opcode_start:    12'd0,
        uleb_value:      64'd0,
        uleb_shift:      7'd0,
        uleb_bytes:      8'd0,
        stopped:         1'b0,
        refuse_seen:     1'b0
    };

    // Request to the register pop summary unit.
    typedef struct packed {
        logic [1:0]  cls;
        logic [4:0]  first;
        logic [15:0] mask;
        logic        wide_slot;
        logic        extra_word;
    } eud_pop_req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  first;
        logic [31:0] mask;
        logic [63:0] stack;
    } eud_pop_res_t;

    typedef struct packed {
        logic [2:0]  op_kind;
        logic [11:0] code_offset;
        logic [7:0]  byte_count;
        logic [1:0]  register_class;
        logic [4:0]  first_register;
        logic [31:0] register_mask;
        logic [63:0] stack_offset;
        logic [1:0]  raw_count;
        logic [7:0]  raw_first;
        logic [7:0]  raw_second;
        logic        refuses_unwind;
        logic [1:0]  stream_status;
    } eud_result_t;

    // Mask with the lowest count bits set, count from 1 to 16.
    function automatic logic [15:0] run_mask(input logic [4:0] count);
        logic [16:0] ones;
        ones = (17'd1 << count) - 17'd1;
        return ones[15:0];
    endfunction

endpackage

[rtl/core/eud_pop_summary.sv]
// Register pop summary: placed mask, register count, lowest register and stack size.
module eud_pop_summary
    import eud_pkg::*;
(
    input  eud_pop_req_t req,
    output eud_pop_res_t res
);

    logic [46:0] placed;
    logic [31:0] kept;
    logic [5:0]  count;
    logic [4:0]  lowest;
    logic [63:0] slots;

    // Registers at number 32 or above fall off the top of the mask.
    assign placed = {31'd0, req.mask} << req.first;
    assign kept   = placed[31:0];

    // Population count and lowest set bit over the fixed 32-bit mask.
    always_comb
    begin
        count  = 6'd0;
        lowest = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            count = count + {5'd0, kept[i]};
        end
        for (int i = 31; i >= 0; i--)
        begin
            if (kept[i])
            begin
                lowest = 5'(i);
            end
        end
    end

    // Four or eight bytes per register, plus one word for the FSTMX forms.
    assign slots = req.wide_slot ? ({58'd0, count} << 3) : ({58'd0, count} << 2);

    always_comb
    begin
        res.kind  = (count > 6'd1) ? KIND_POP_MANY : KIND_POP_ONE;
        res.first = lowest;
        res.mask  = kept;
        res.stack = slots + (req.extra_word ? 64'd4 : 64'd0);
    end

endmodule

[rtl/core/eud_decoder.sv]
// Combinational opcode decoder: next stream state and the result for one byte.
module eud_decoder
    import eud_pkg::*;
#(
    parameter int POS_CAP = 4095
)
(
    input  eud_state_t  state,
    input  logic [7:0]  byte_value,
    input  logic        end_of_stream,
    output eud_state_t  state_next,
    output logic        done,
    output eud_result_t result
);

    eud_pop_req_t pop_req;
    eud_pop_res_t pop_res;
    logic         pop_sel;
    eud_result_t  base;
    logic [7:0]   b;
    logic [7:0]   h;
    logic [11:0]  pair_mask;
    logic [63:0]  uleb_shifted;
    logic [63:0]  uleb_merged;
    logic [7:0]   uleb_count;

    assign b = byte_value;
    assign h = state.held_first_byte;
    assign pair_mask = {h[3:0], b};
    assign uleb_shifted = {57'd0, b[6:0]} << state.uleb_shift[5:0];
    assign uleb_merged = state.uleb_value | uleb_shifted;
    assign uleb_count = state.uleb_bytes + 8'd1;

    eud_pop_summary u_pop (
        .req (pop_req),
        .res (pop_res)
    );

    // Main decode of the byte against the pending opcode.
    always_comb
    begin
        state_next = state;
        base       = '0;
        done       = 1'b0;
        pop_sel    = 1'b0;
        pop_req    = '0;
        if (state.stopped)
        begin
            // Bytes after finish are dropped until the stream ends.
            if (end_of_stream)
            begin
                state_next = STATE_CLEAR;
            end
        end
        else
        begin
            case (state.pending)
                PEND_NONE:
                begin
                    state_next.opcode_start = state.byte_position;
                    base.byte_count = 8'd1;
                    done = 1'b1;
                    if (b[7:6] == GRP_ALLOC || b[7:6] == GRP_DEALLOC)
                    begin
                        base.op_kind = (b[7:6] == GRP_DEALLOC) ? KIND_DEALLOC : KIND_ALLOC;
                        base.stack_offset = {56'd0, b[5:0], 2'b00} + 64'd4;
                    end
                    else if (b[7:4] == GRP_POP_MASK || b == OP_POP_LOW || b == OP_VFP_X ||
                             b == OP_SPARE_A || b == OP_SPARE_B || b == OP_VFP_HI ||
                             b == OP_VFP_LO)
                    begin
                        state_next.pending = PEND_PAIR;
                        state_next.held_first_byte = b;
                        done = 1'b0;
                    end
                    else if (b == OP_ULEB)
                    begin
                        state_next.pending = PEND_ULEB;
                        state_next.uleb_value = 64'd0;
                        state_next.uleb_shift = 7'd0;
                        state_next.uleb_bytes = 8'd0;
                        done = 1'b0;
                    end
                    else if (b[7:4] == GRP_SP_MOVE)
                    begin
                        if (b[3:0] == REG_SP || b[3:0] == REG_PC)
                        begin
                            base.op_kind = KIND_OPAQUE;
                            base.raw_count = 2'd1;
                            base.raw_first = b;
                        end
                        else
                        begin
                            base.op_kind = KIND_SP_MOVE;
                            base.register_class = CLS_GP;
                            base.first_register = {1'b0, b[3:0]};
                            base.register_mask = 32'd1 << b[3:0];
                        end
                    end
                    else if (b[7:3] == GRP_POP_R4 || b[7:3] == GRP_POP_R4_LR)
                    begin
                        pop_sel = 1'b1;
                        pop_req.cls = CLS_GP;
                        pop_req.first = 5'd4;
                        pop_req.mask = run_mask({2'd0, b[2:0]} + 5'd1);
                        if (b[7:3] == GRP_POP_R4_LR)
                        begin
                            // The link register sits at bit 10 above r4.
                            pop_req.mask[10] = 1'b1;
                        end
                    end
                    else if (b == OP_FINISH)
                    begin
                        base.op_kind = KIND_FINISH;
                        base.stream_status = STAT_FINISH;
                        state_next.stopped = 1'b1;
                    end
                    else if (b[7:3] == GRP_VFP_D8X || b[7:3] == GRP_VFP_D8)
                    begin
                        pop_sel = 1'b1;
                        pop_req.cls = CLS_FP;
                        pop_req.first = 5'd8;
                        pop_req.mask = run_mask({2'd0, b[2:0]} + 5'd1);
                        pop_req.wide_slot = 1'b1;
                        pop_req.extra_word = (b[7:3] == GRP_VFP_D8X);
                    end
                    else
                    begin
                        base.op_kind = KIND_OPAQUE;
                        base.raw_count = 2'd1;
                        base.raw_first = b;
                    end
                end
                PEND_PAIR:
                begin
                    state_next.pending = PEND_NONE;
                    base.byte_count = 8'd2;
                    done = 1'b1;
                    base.op_kind = KIND_OPAQUE;
                    base.raw_count = 2'd2;
                    base.raw_first = h;
                    base.raw_second = b;
                    if (h[7:4] == GRP_POP_MASK)
                    begin
                        if (pair_mask == 12'd0)
                        begin
                            // Reserved empty mask marks the frame as not unwindable.
                            state_next.refuse_seen = 1'b1;
                        end
                        else
                        begin
                            pop_sel = 1'b1;
                            pop_req.cls = CLS_GP;
                            pop_req.first = 5'd4;
                            pop_req.mask = {4'd0, pair_mask};
                        end
                    end
                    else if (h == OP_POP_LOW)
                    begin
                        if (b != 8'd0 && b[7:4] == 4'd0)
                        begin
                            pop_sel = 1'b1;
                            pop_req.cls = CLS_GP;
                            pop_req.first = 5'd0;
                            pop_req.mask = {12'd0, b[3:0]};
                        end
                    end
                    else if (h == OP_VFP_X || h == OP_VFP_HI || h == OP_VFP_LO)
                    begin
                        pop_sel = 1'b1;
                        pop_req.cls = CLS_FP;
                        pop_req.first = (h == OP_VFP_HI) ? {1'b1, b[7:4]} : {1'b0, b[7:4]};
                        pop_req.mask = run_mask({1'b0, b[3:0]} + 5'd1);
                        pop_req.wide_slot = 1'b1;
                        pop_req.extra_word = (h == OP_VFP_X);
                    end
                end
                PEND_ULEB:
                begin
                    // Operand bits at shift 64 or beyond are dropped.
                    if (state.uleb_shift < 7'd64)
                    begin
                        state_next.uleb_value = uleb_merged;
                        state_next.uleb_shift = state.uleb_shift + 7'd7;
                    end
                    state_next.uleb_bytes = uleb_count;
                    if (!b[7])
                    begin
                        base.op_kind = KIND_ALLOC;
                        base.byte_count = uleb_count + 8'd1;
                        base.stack_offset = ULEB_BASE + (state_next.uleb_value << 2);
                        state_next.pending = PEND_NONE;
                        done = 1'b1;
                    end
                end
                default:
                begin
                    state_next.pending = PEND_NONE;
                end
            endcase

            // The offset counter saturates at its cap.
            if (state.byte_position < 12'(POS_CAP))
            begin
                state_next.byte_position = state.byte_position + 12'd1;
            end

            if (end_of_stream)
            begin
                if (!done)
                begin
                    base = '0;
                    base.op_kind = KIND_NONE;
                    base.stream_status = STAT_TRUNC;
                    done = 1'b1;
                end
                else if (base.stream_status == STAT_MORE)
                begin
                    base.stream_status = STAT_END_OK;
                end
            end
            base.code_offset = state_next.opcode_start;
            base.refuses_unwind = state_next.refuse_seen;
            if (end_of_stream)
            begin
                state_next = STATE_CLEAR;
            end
        end
    end

    // Merge in the pop summary for register pop opcodes; a pop carries no raw bytes.
    always_comb
    begin
        result = base;
        if (pop_sel)
        begin
            result.op_kind        = pop_res.kind;
            result.register_class = pop_req.cls;
            result.first_register = pop_res.first;
            result.register_mask  = pop_res.mask;
            result.stack_offset   = pop_res.stack;
            result.raw_count      = 2'd0;
            result.raw_first      = 8'd0;
            result.raw_second     = 8'd0;
        end
    end

endmodule

[rtl/core/ehabi_unwind_opcode_decoder_core.sv]
// EHABI unwind opcode decoder: input register, single-pass decode, result register.
// An accepted byte is held in the input register, decoded, and its result is captured in the result register.
// Throughput: one stream byte per cycle while the result side is not stalled, set by the single-pass decode.
// A waiting result does not block intake while the result register can be refilled.
// Reset (rst_n low, asynchronous) clears all stream state and both valid flags.
module ehabi_unwind_opcode_decoder_core
    import eud_pkg::*;
#(
    parameter int MAX_STREAM_BYTES = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // byte_value[7:0]
    input  logic                  s_axis_tlast,  // end_of_stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // op_kind[2:0], code_offset[14:3], byte_count[22:15], register_class[24:23],
    // first_register[29:25], register_mask[61:30], stack_offset[125:62],
    // raw_count[127:126], raw_first[135:128], raw_second[143:136],
    // refuses_unwind[144], stream_status[146:145], zero pad [151:147]
    output logic [TDATA_BITS-1:0] m_axis_tdata
);

    localparam int POS_CAP = (MAX_STREAM_BYTES - 1 < 4095) ? MAX_STREAM_BYTES - 1 : 4095;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    eud_state_t  state_reg;
    eud_state_t  state_next;
    logic        out_valid_reg;
    eud_result_t out_result_reg;
    eud_result_t dec_result;
    logic        dec_done;
    logic        out_free;
    logic        consume;
    logic        s_accept;

    eud_decoder #(
        .POS_CAP (POS_CAP)
    ) u_decoder (
        .state         (state_reg),
        .byte_value    (in_byte_reg),
        .end_of_stream (in_last_reg),
        .state_next    (state_next),
        .done          (dec_done),
        .result        (dec_result)
    );

    // A held byte retires when it yields no result or the result slot frees up.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign consume       = in_valid_reg && (!dec_done || out_free);
    assign s_axis_tready = !in_valid_reg || consume;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Input register control and stream state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_valid_reg <= 1'b0;
            end
            if (consume)
            begin
                state_reg <= state_next;
            end
            if (consume && dec_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (consume && dec_done)
        begin
            out_result_reg <= dec_result;
        end
    end

    // Pack the result transfer, first field in the lowest bits.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        5'd0,
        out_result_reg.stream_status,
        out_result_reg.refuses_unwind,
        out_result_reg.raw_second,
        out_result_reg.raw_first,
        out_result_reg.raw_count,
        out_result_reg.stack_offset,
        out_result_reg.register_mask,
        out_result_reg.first_register,
        out_result_reg.register_class,
        out_result_reg.byte_count,
        out_result_reg.code_offset,
        out_result_reg.op_kind
    };

endmodule

[tb/sv/unwind_decode_checker.sv]
// Scoreboard for the unwind opcode decoder: predicts each decoded opcode and checks the results.
`timescale 1ns / 1ps

module unwind_decode_checker
    import eud_pkg::*;
#(
    parameter int MAX_STREAM_BYTES = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [TDATA_BITS-1:0] m_axis_tdata,
    output int                    fail_count,
    output int                    outstanding,
    output int                    decoded_bytes
);

    localparam int POS_CAP = (MAX_STREAM_BYTES - 1 < 4095) ? MAX_STREAM_BYTES - 1 : 4095;

    // Our own copy of the decode state for the current stream.
    pend_t       pend;
    logic [7:0]  held_byte;
    logic [11:0] byte_pos;
    logic [11:0] op_start;
    logic [63:0] uleb_acc;
    logic [6:0]  uleb_sh;
    logic [7:0]  uleb_len;
    logic        halted;
    logic        refused;

    eud_result_t predicted_ops[$];
    int          errors;
    int          bytes_decoded;

    initial begin
        fail_count    = 0;
        outstanding   = 0;
        decoded_bytes = 0;
        errors        = 0;
        bytes_decoded = 0;
    end

    // Return to the start-of-stream state.
    function automatic void clear_stream();
        pend      = PEND_NONE;
        held_byte = '0;
        byte_pos  = '0;
        op_start  = '0;
        uleb_acc  = '0;
        uleb_sh   = '0;
        uleb_len  = '0;
        halted    = 1'b0;
        refused   = 1'b0;
    endfunction

    function automatic logic [31:0] low_ones(input int n);
        return (n >= 32) ? 32'hFFFF_FFFF : ((32'h1 << n) - 32'h1);
    endfunction

    // Fill in a register pop; registers numbered 32 and up are dropped.
    function automatic void fill_pop(inout eud_result_t r, input logic [1:0] cls, input int base,
                                     input logic [31:0] sel, input int slot);
        int count;
        int lowest;
        int regno;
        bit seen;
        count  = 0;
        lowest = 0;
        seen   = 0;
        r.register_class = cls;
        for (int idx = 0; idx < 32; idx++) begin
            regno = base + idx;
            if (sel[idx] && regno < 32) begin
                r.register_mask[regno] = 1'b1;
                count++;
                if (!seen) begin
                    lowest = regno;
                    seen   = 1;
                end
            end
        end
        r.first_register = 5'(lowest);
        r.stack_offset   = 64'(count) * 64'(slot);
        r.op_kind        = (count > 1) ? KIND_POP_MANY : KIND_POP_ONE;
    endfunction

    function automatic void fill_raw(inout eud_result_t r, input logic [1:0] n,
                                     input logic [7:0] a, input logic [7:0] b);
        r.op_kind    = KIND_OPAQUE;
        r.raw_count  = n;
        r.raw_first  = a;
        r.raw_second = (n > 2'd1) ? b : 8'd0;
    endfunction

    // Decode a lead byte; returns 1 when the opcode is complete in one byte.
    function automatic bit decode_lead(inout eud_result_t r, input logic [7:0] b);
        r.byte_count = 8'd1;
        if (b[7:6] == GRP_ALLOC || b[7:6] == GRP_DEALLOC) begin
            r.op_kind      = (b[7:6] == GRP_ALLOC) ? KIND_ALLOC : KIND_DEALLOC;
            r.stack_offset = {56'd0, b[5:0], 2'b00} + 64'd4;
        end else if (b[7:4] == GRP_POP_MASK || b == OP_POP_LOW || b == OP_VFP_X ||
                     b == OP_SPARE_A || b == OP_SPARE_B || b == OP_VFP_HI || b == OP_VFP_LO) begin
            pend      = PEND_PAIR;
            held_byte = b;
            return 0;
        end else if (b == OP_ULEB) begin
            pend     = PEND_ULEB;
            uleb_acc = '0;
            uleb_sh  = '0;
            uleb_len = '0;
            return 0;
        end else if (b[7:4] == GRP_SP_MOVE) begin
            if (b[3:0] == REG_SP || b[3:0] == REG_PC) begin
                fill_raw(r, 2'd1, b, 8'd0);
            end else begin
                r.op_kind        = KIND_SP_MOVE;
                r.register_class = CLS_GP;
                r.first_register = {1'b0, b[3:0]};
                r.register_mask  = 32'h1 << b[3:0];
            end
        end else if (b[7:3] == GRP_POP_R4) begin
            fill_pop(r, CLS_GP, 4, low_ones(int'(b[2:0]) + 1), 4);
        end else if (b[7:3] == GRP_POP_R4_LR) begin
            fill_pop(r, CLS_GP, 4, low_ones(int'(b[2:0]) + 1) | (32'h1 << 10), 4);
        end else if (b == OP_FINISH) begin
            r.op_kind       = KIND_FINISH;
            r.stream_status = STAT_FINISH;
            halted          = 1'b1;
        end else if (b[7:3] == GRP_VFP_D8X) begin
            fill_pop(r, CLS_FP, 8, low_ones(int'(b[2:0]) + 1), 8);
            r.stack_offset += 64'd4;
        end else if (b[7:3] == GRP_VFP_D8) begin
            fill_pop(r, CLS_FP, 8, low_ones(int'(b[2:0]) + 1), 8);
        end else begin
            fill_raw(r, 2'd1, b, 8'd0);
        end
        return 1;
    endfunction

    // Decode the operand byte of a two-byte opcode.
    function automatic void decode_pair(inout eud_result_t r, input logic [7:0] h,
                                        input logic [7:0] b);
        logic [11:0] sel;
        r.byte_count = 8'd2;
        sel = {h[3:0], b};
        if (h[7:4] == GRP_POP_MASK) begin
            if (sel == 12'd0) begin
                refused = 1'b1;
                fill_raw(r, 2'd2, h, b);
            end else begin
                fill_pop(r, CLS_GP, 4, {20'd0, sel}, 4);
            end
        end else if (h == OP_POP_LOW) begin
            if (b == 8'd0 || b[7:4] != 4'd0)
                fill_raw(r, 2'd2, h, b);
            else
                fill_pop(r, CLS_GP, 0, {28'd0, b[3:0]}, 4);
        end else if (h == OP_VFP_X) begin
            fill_pop(r, CLS_FP, int'(b[7:4]), low_ones(int'(b[3:0]) + 1), 8);
            r.stack_offset += 64'd4;
        end else if (h == OP_VFP_HI || h == OP_VFP_LO) begin
            fill_pop(r, CLS_FP, int'(b[7:4]) + ((h == OP_VFP_HI) ? 16 : 0),
                     low_ones(int'(b[3:0]) + 1), 8);
        end else begin
            fill_raw(r, 2'd2, h, b);
        end
    endfunction

    // Advance the decode state by one stream byte; returns 1 when a result is due.
    function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                       output eud_result_t r);
        bit done;
        r    = '0;
        done = 0;
        if (halted) begin
            if (eos)
                clear_stream();
            return 0;
        end
        case (pend)
            PEND_NONE: begin
                op_start = byte_pos;
                done     = decode_lead(r, b);
            end
            PEND_PAIR: begin
                decode_pair(r, held_byte, b);
                pend = PEND_NONE;
                done = 1;
            end
            default: begin
                if (uleb_sh < 7'd64) begin
                    uleb_acc = uleb_acc | ({57'd0, b[6:0]} << uleb_sh);
                    uleb_sh  = uleb_sh + 7'd7;
                end
                uleb_len = uleb_len + 8'd1;
                if (!b[7]) begin
                    r.op_kind      = KIND_ALLOC;
                    r.byte_count   = uleb_len + 8'd1;
                    r.stack_offset = ULEB_BASE + (uleb_acc << 2);
                    pend           = PEND_NONE;
                    done           = 1;
                end
            end
        endcase
        if (int'(byte_pos) < POS_CAP)
            byte_pos = byte_pos + 12'd1;

        // The end mark closes the stream, cutting off an unfinished opcode.
        if (eos) begin
            if (!done) begin
                r               = '0;
                r.op_kind       = KIND_NONE;
                r.stream_status = STAT_TRUNC;
                done            = 1;
            end else if (r.stream_status == STAT_MORE) begin
                r.stream_status = STAT_END_OK;
            end
        end
        if (done) begin
            r.code_offset    = op_start;
            r.refuses_unwind = refused;
        end
        if (eos)
            clear_stream();
        return done;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Check result transfers against the oldest prediction, then predict from input transfers.
    always @(posedge clk or negedge rst_n) begin
        eud_result_t want;
        logic        live;
        if (!rst_n) begin
            clear_stream();
            predicted_ops.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_ops.size() == 0) begin
                    $error("result transfer with no decoded opcode waiting");
                    errors++;
                end else begin
                    want = predicted_ops.pop_front();
                    compare_field("op_kind", want.op_kind, m_axis_tdata[2:0]);
                    compare_field("code_offset", want.code_offset, m_axis_tdata[14:3]);
                    compare_field("byte_count", want.byte_count, m_axis_tdata[22:15]);
                    compare_field("register_class", want.register_class, m_axis_tdata[24:23]);
                    compare_field("first_register", want.first_register, m_axis_tdata[29:25]);
                    compare_field("register_mask", want.register_mask, m_axis_tdata[61:30]);
                    compare_field("stack_offset", want.stack_offset, m_axis_tdata[125:62]);
                    compare_field("raw_count", want.raw_count, m_axis_tdata[127:126]);
                    compare_field("raw_first", want.raw_first, m_axis_tdata[135:128]);
                    compare_field("raw_second", want.raw_second, m_axis_tdata[143:136]);
                    compare_field("refuses_unwind", want.refuses_unwind, m_axis_tdata[144]);
                    compare_field("stream_status", want.stream_status, m_axis_tdata[146:145]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                live = !halted;
                if (decode_byte(s_axis_tdata, s_axis_tlast, want))
                    predicted_ops.push_back(want);
                if (live)
                    bytes_decoded++;
            end
        end
        fail_count    <= errors;
        outstanding   <= predicted_ops.size();
        decoded_bytes <= bytes_decoded;
    end

endmodule

[tb/sv/tb.sv]
// Top of the unwind opcode decoder testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import eud_pkg::*;

    localparam int MAX_BYTES     = 4096;
    localparam int RANDOM_BYTES  = 150;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = 8'd0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_axis_tdata;

    int fail_count;
    int outstanding;
    int decoded_bytes;

    // Bytes of the stream being sent next, and the no-idle stretch counters.
    logic [7:0] run_bytes[$];
    int         send_calm = 0;
    int         recv_calm = 0;

    ehabi_unwind_opcode_decoder_core #(
        .MAX_STREAM_BYTES(MAX_BYTES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    unwind_decode_checker #(
        .MAX_STREAM_BYTES(MAX_BYTES)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .decoded_bytes(decoded_bytes)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Idle cycles before the next transfer, with occasional stretches of none.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, 14);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic mark);
        int gap;
        gap = draw_gap(send_calm);
        repeat (gap) begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= mark;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Send the queued bytes; the final one always carries the end mark.
    task automatic send_run(input bit loose_marks);
        logic [7:0] b;
        logic       mark;
        while (run_bytes.size() > 0) begin
            b    = run_bytes.pop_front();
            mark = (run_bytes.size() == 0) || (loose_marks && $urandom_range(0, 4) == 0);
            send_byte(b, mark);
        end
    endtask

    // Queue one complete opcode with random content.
    task automatic add_op(output bit finished);
        logic [7:0] lead;
        int         n;
        case ($urandom_range(0, 5))
            0: lead = {GRP_POP_MASK, 4'($urandom)};
            1: begin
                case ($urandom_range(0, 7))
                    0: lead = OP_POP_LOW;
                    1: lead = OP_ULEB;
                    2: lead = OP_VFP_X;
                    3: lead = OP_SPARE_A;
                    4: lead = OP_SPARE_B;
                    5: lead = OP_VFP_HI;
                    6: lead = OP_VFP_LO;
                    default: lead = OP_FINISH;
                endcase
            end
            default: lead = 8'($urandom);
        endcase
        finished = (lead == OP_FINISH);
        run_bytes.push_back(lead);
        if (lead[7:4] == GRP_POP_MASK || lead == OP_POP_LOW || lead == OP_VFP_X ||
            (lead >= OP_SPARE_A && lead <= OP_VFP_LO)) begin
            case ($urandom_range(0, 3))
                0: run_bytes.push_back(8'd0);
                1: run_bytes.push_back({4'd0, 4'($urandom)});
                default: run_bytes.push_back(8'($urandom));
            endcase
        end else if (lead == OP_ULEB) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
            repeat (n - 1) run_bytes.push_back(8'($urandom) | 8'h80);
            run_bytes.push_back(8'($urandom) & 8'h7F);
        end
    endtask

    // Result side: accept with random stalls.
    initial begin
        int gap;
        forever begin
            gap = draw_gap(recv_calm);
            repeat (gap) begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Stimulus and verdict.
    initial begin
        int  goal;
        int  ops;
        bit  finished;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Field extremes, single-byte groups, reserved mask zero, then a pop that shows it.
        run_bytes = '{8'h00, 8'h3F, 8'h7F, 8'h9D, 8'hA7, 8'hAF, 8'hB8, 8'hD7,
                      8'h80, 8'h00, 8'h8F, 8'hFF};
        send_run(0);
        // Low-register pop edge cases, VFP pop past register 31, finish then ignored bytes.
        run_bytes = '{OP_POP_LOW, 8'h00, OP_POP_LOW, 8'h0F, OP_VFP_HI, 8'hFF,
                      OP_FINISH, 8'h12};
        send_run(0);
        // Stream cut inside a uleb128 operand.
        run_bytes = '{OP_ULEB, 8'h80};
        send_run(0);
        // Finish carrying the end mark itself.
        run_bytes = '{OP_FINISH};
        send_run(0);

        // Hold off until every outstanding result has drained.
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge clk);

        // A uleb128 operand long enough to wrap its byte count, then one more opcode.
        run_bytes.push_back(OP_ULEB);
        repeat (260) run_bytes.push_back(8'($urandom) | 8'h80);
        run_bytes.push_back(8'h01);
        run_bytes.push_back(8'h05);
        send_run(0);

        // Random streams: mostly well formed, some cut short, some noise.
        goal = decoded_bytes + RANDOM_BYTES;
        while (decoded_bytes < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) run_bytes.push_back(8'($urandom));
                send_run(1);
            end else begin
                ops      = $urandom_range(1, 8);
                finished = 0;
                for (int i = 0; i < ops && !finished; i++)
                    add_op(finished);
                if (finished) begin
                    repeat ($urandom_range(0, 4)) run_bytes.push_back(8'($urandom));
                end else if ($urandom_range(0, 6) == 0) begin
                    if ($urandom_range(0, 1) == 0) begin
                        run_bytes.push_back({GRP_POP_MASK, 4'($urandom)});
                    end else begin
                        run_bytes.push_back(OP_ULEB);
                        repeat ($urandom_range(0, 3)) run_bytes.push_back(8'($urandom) | 8'h80);
                    end
                end
                send_run(0);
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/eud_pkg.sv
rtl/core/eud_pop_summary.sv
rtl/core/eud_decoder.sv
rtl/core/ehabi_unwind_opcode_decoder_core.sv
tb/sv/unwind_decode_checker.sv
tb/sv/tb.sv
